FILE: hw/rtl/scd_pkg.sv
// ----------------------------------------------------------------------------
// scd_pkg
// Shared types and constants of the sector cache directory.
// ----------------------------------------------------------------------------
package scd_pkg;

    localparam int SLOTS_DEF = 64;
    localparam int MAX_OUT   = 64;
    localparam int KW        = $clog2(MAX_OUT + 1);
    localparam logic [7:0] RCNT_MAX = 8'hFF;

    typedef enum logic [2:0] {
        CMD_LOCK_SH = 3'd0,
        CMD_LOCK_EX = 3'd1,
        CMD_UNLOCK  = 3'd2,
        CMD_FILL    = 3'd3,
        CMD_ZERO    = 3'd4,
        CMD_DIRTY   = 3'd5,
        CMD_FREE    = 3'd6,
        CMD_FLUSH   = 3'd7
    } t_cmd;

    typedef enum logic [2:0] {
        ST_HIT   = 3'd0,
        ST_ALLOC = 3'd1,
        ST_EVICT = 3'd2,
        ST_BUSY  = 3'd3,
        ST_FULL  = 3'd4,
        ST_DONE  = 3'd5,
        ST_ERROR = 3'd6
    } t_status;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_RD,
        S_EV,
        S_HAND_RD,
        S_HAND_EV,
        S_FL_END
    } t_state;

    // per-slot state word held in the status memory
    typedef struct packed {
        logic       valid;
        logic [7:0] rcnt;
        logic       wr;
        logic       utd;
        logic       dirty;
    } t_stat;

    // one result beat
    typedef struct packed {
        t_status     status;
        logic [5:0]  slot;
        logic [31:0] sector;
        logic        wb;
        logic        rn;
        logic        last;
    } t_res;

endpackage

FILE: hw/rtl/scd_mem.sv
// ----------------------------------------------------------------------------
// scd_mem
// Tag and status memories of the directory, one read and one write port
// each, read data registered.
// ----------------------------------------------------------------------------
module scd_mem #(
    parameter int SLOTS = scd_pkg::SLOTS_DEF,
    parameter int IW    = $clog2(SLOTS)
) (
    input  logic              i_clk,
    input  logic [IW-1:0]     i_rd_addr,
    output logic [31:0]       o_tag,
    output scd_pkg::t_stat    o_stat,
    input  logic              i_tag_we,
    input  logic [IW-1:0]     i_tag_wa,
    input  logic [31:0]       i_tag_wd,
    input  logic              i_st_we,
    input  logic [IW-1:0]     i_st_wa,
    input  scd_pkg::t_stat    i_st_wd
);

    logic [31:0]    tag_mem [SLOTS];
    scd_pkg::t_stat st_mem  [SLOTS];

    // tag memory
    always_ff @(posedge i_clk) begin
        if (i_tag_we) begin
            tag_mem[i_tag_wa] <= i_tag_wd;
        end
        o_tag <= tag_mem[i_rd_addr];
    end

    // status memory
    always_ff @(posedge i_clk) begin
        if (i_st_we) begin
            st_mem[i_st_wa] <= i_st_wd;
        end
        o_stat <= st_mem[i_rd_addr];
    end

endmodule

FILE: hw/rtl/sector_cache_directory_core.sv
// ----------------------------------------------------------------------------
// sector_cache_directory_core
// Directory of a fully associative sector cache with pin counts and
// clock-hand replacement.
// ----------------------------------------------------------------------------
// One command is handled at a time. Every slot visit has two steps: the
// tag and status memories are read, then the slot is checked and written
// back. Unlock, fill, zero and mark dirty visit only the given slot. Lock
// and free scan the directory from slot 0 until a hit; a lock that misses
// with no free slot then walks the clock hand. Flush scans the slots from
// slot 0 and stops early once MAX_OUT write-backs are found; it waits on
// any output stall. After reset a clearing pass writes the status memory
// before the first command is taken. The next command is taken once the
// last result beat has left the output register.
// ----------------------------------------------------------------------------
module sector_cache_directory_core #(
    parameter int SLOTS = scd_pkg::SLOTS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [2:0]  i_cmd,
    input  logic [31:0] i_sector,
    input  logic [5:0]  i_slot,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [2:0]  o_status,
    output logic [5:0]  o_slot_out,
    output logic [31:0] o_disk_sector,
    output logic        o_write_back,
    output logic        o_read_needed,
    output logic        o_last
);

    localparam int IW = $clog2(SLOTS);
    localparam int NW = IW + 1;
    localparam logic [IW-1:0] LAST_IDX = IW'(SLOTS - 1);

    scd_pkg::t_state r_state, n_state;
    scd_pkg::t_cmd   r_cmd, n_cmd;
    logic [31:0]     r_sector, n_sector;
    logic [5:0]      r_slot, n_slot;
    logic [IW-1:0]   r_idx, n_idx;
    logic [IW-1:0]   r_hand, n_hand;
    logic [NW-1:0]   r_n, n_n;
    logic            r_free_v, n_free_v;
    logic [IW-1:0]   r_free_idx, n_free_idx;
    logic [scd_pkg::KW-1:0] r_k, n_k;
    logic            r_hold_v, n_hold_v;
    logic [IW-1:0]   r_hold_idx, n_hold_idx;
    logic [31:0]     r_hold_tag, n_hold_tag;
    logic            r_o_valid, n_o_valid;
    scd_pkg::t_res   r_res, n_res;

    logic [IW-1:0]   rd_addr;
    logic [31:0]     q_tag;
    scd_pkg::t_stat  q_st;
    logic            tag_we, st_we;
    logic [IW-1:0]   tag_wa, st_wa;
    logic [31:0]     tag_wd;
    scd_pkg::t_stat  st_wd;

    logic            o_free, accept, pinned, hit, cand, excl;

    scd_mem #(.SLOTS(SLOTS), .IW(IW)) u_mem (
        .i_clk     (i_clk),
        .i_rd_addr (rd_addr),
        .o_tag     (q_tag),
        .o_stat    (q_st),
        .i_tag_we  (tag_we),
        .i_tag_wa  (tag_wa),
        .i_tag_wd  (tag_wd),
        .i_st_we   (st_we),
        .i_st_wa   (st_wa),
        .i_st_wd   (st_wd)
    );

    // handshake and entry decode
    assign o_free     = !r_o_valid || i_out_ready;
    assign o_in_ready = (r_state == scd_pkg::S_IDLE) && !r_o_valid;
    assign accept     = i_in_valid && o_in_ready;
    assign pinned     = (q_st.rcnt != 8'd0) || q_st.wr;
    assign hit        = q_st.valid && (q_tag == r_sector);
    assign cand       = q_st.valid && q_st.utd && q_st.dirty && !q_st.wr;
    assign excl       = (r_cmd == scd_pkg::CMD_LOCK_EX);

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= scd_pkg::S_CLEAR;
            r_idx     <= '0;
            r_hand    <= '0;
            r_o_valid <= 1'b0;
            r_hold_v  <= 1'b0;
            r_free_v  <= 1'b0;
            r_k       <= '0;
            r_n       <= '0;
        end else begin
            r_state   <= n_state;
            r_idx     <= n_idx;
            r_hand    <= n_hand;
            r_o_valid <= n_o_valid;
            r_hold_v  <= n_hold_v;
            r_free_v  <= n_free_v;
            r_k       <= n_k;
            r_n       <= n_n;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_cmd      <= n_cmd;
        r_sector   <= n_sector;
        r_slot     <= n_slot;
        r_free_idx <= n_free_idx;
        r_hold_idx <= n_hold_idx;
        r_hold_tag <= n_hold_tag;
        r_res      <= n_res;
    end

    // next state, memory access and result beats
    always_comb begin
        n_state    = r_state;
        n_cmd      = r_cmd;
        n_sector   = r_sector;
        n_slot     = r_slot;
        n_idx      = r_idx;
        n_hand     = r_hand;
        n_n        = r_n;
        n_free_v   = r_free_v;
        n_free_idx = r_free_idx;
        n_k        = r_k;
        n_hold_v   = r_hold_v;
        n_hold_idx = r_hold_idx;
        n_hold_tag = r_hold_tag;
        n_o_valid  = r_o_valid && !i_out_ready;
        n_res      = r_res;
        rd_addr    = (r_state == scd_pkg::S_HAND_RD || r_state == scd_pkg::S_HAND_EV)
                     ? r_hand : r_idx;
        tag_we     = 1'b0;
        tag_wa     = r_idx;
        tag_wd     = r_sector;
        st_we      = 1'b0;
        st_wa      = r_idx;
        st_wd      = q_st;

        case (r_state)
            // clearing pass over the status memory
            scd_pkg::S_CLEAR: begin
                st_we = 1'b1;
                st_wd = '0;
                n_idx = r_idx + 1'b1;
                if (r_idx == LAST_IDX) begin
                    n_idx   = '0;
                    n_state = scd_pkg::S_IDLE;
                end
            end

            scd_pkg::S_IDLE: begin
                if (accept) begin
                    n_cmd    = scd_pkg::t_cmd'(i_cmd);
                    n_sector = i_sector;
                    n_slot   = i_slot;
                    n_idx    = '0;
                    n_free_v = 1'b0;
                    n_hold_v = 1'b0;
                    n_k      = '0;
                    n_state  = scd_pkg::S_RD;
                    if (i_cmd inside {scd_pkg::CMD_UNLOCK, scd_pkg::CMD_FILL,
                                      scd_pkg::CMD_ZERO, scd_pkg::CMD_DIRTY}) begin
                        if (32'(i_slot) < 32'(SLOTS)) begin
                            n_idx = IW'(i_slot);
                        end else begin
                            n_state   = scd_pkg::S_IDLE;
                            n_o_valid = 1'b1;
                            n_res     = '{scd_pkg::ST_ERROR, i_slot, 32'd0, 1'b0,
                                          1'b0, 1'b1};
                        end
                    end
                end
            end

            scd_pkg::S_RD: begin
                n_state = scd_pkg::S_EV;
            end

            scd_pkg::S_EV: begin
                n_state = scd_pkg::S_IDLE;
                case (r_cmd)
                    // lookup, free-slot search
                    scd_pkg::CMD_LOCK_SH, scd_pkg::CMD_LOCK_EX, scd_pkg::CMD_FREE: begin
                        if (hit) begin
                            n_o_valid = 1'b1;
                            if (r_cmd == scd_pkg::CMD_FREE) begin
                                st_wd.valid = 1'b0;
                                st_we       = !pinned;
                                n_res = '{scd_pkg::ST_DONE, 6'd0, 32'd0, 1'b0, 1'b0, 1'b1};
                            end else if (excl ? pinned
                                         : (q_st.wr || q_st.rcnt == scd_pkg::RCNT_MAX)) begin
                                n_res = '{scd_pkg::ST_BUSY, 6'(r_idx), 32'd0, 1'b0,
                                          1'b0, 1'b1};
                            end else begin
                                st_we = 1'b1;
                                if (excl) begin
                                    st_wd.wr = 1'b1;
                                end else begin
                                    st_wd.rcnt = q_st.rcnt + 8'd1;
                                end
                                n_res = '{scd_pkg::ST_HIT, 6'(r_idx), 32'd0, 1'b0,
                                          1'b0, 1'b1};
                            end
                        end else begin
                            if (!q_st.valid && !r_free_v) begin
                                n_free_v   = 1'b1;
                                n_free_idx = r_idx;
                            end
                            if (r_idx != LAST_IDX) begin
                                n_idx   = r_idx + 1'b1;
                                n_state = scd_pkg::S_RD;
                            end else if (r_cmd == scd_pkg::CMD_FREE) begin
                                n_o_valid = 1'b1;
                                n_res = '{scd_pkg::ST_DONE, 6'd0, 32'd0, 1'b0, 1'b0, 1'b1};
                            end else if (n_free_v) begin
                                st_we  = 1'b1;
                                st_wa  = n_free_idx;
                                st_wd  = '{1'b1, excl ? 8'd0 : 8'd1, excl, 1'b0, 1'b0};
                                tag_we = 1'b1;
                                tag_wa = n_free_idx;
                                n_o_valid = 1'b1;
                                n_res = '{scd_pkg::ST_ALLOC, 6'(n_free_idx), 32'd0,
                                          1'b0, 1'b0, 1'b1};
                            end else begin
                                n_n     = '0;
                                n_state = scd_pkg::S_HAND_RD;
                            end
                        end
                    end

                    scd_pkg::CMD_UNLOCK: begin
                        n_o_valid = 1'b1;
                        if (!q_st.valid || !pinned) begin
                            n_res = '{scd_pkg::ST_ERROR, r_slot, 32'd0, 1'b0, 1'b0, 1'b1};
                        end else begin
                            st_we = 1'b1;
                            if (q_st.rcnt != 8'd0) begin
                                st_wd.rcnt = q_st.rcnt - 8'd1;
                            end else begin
                                st_wd.wr = 1'b0;
                            end
                            n_res = '{scd_pkg::ST_DONE, r_slot, 32'd0, 1'b0, 1'b0, 1'b1};
                        end
                    end

                    scd_pkg::CMD_FILL: begin
                        n_o_valid = 1'b1;
                        if (!q_st.valid || !pinned) begin
                            n_res = '{scd_pkg::ST_ERROR, r_slot, 32'd0, 1'b0, 1'b0, 1'b1};
                        end else if (!q_st.utd) begin
                            st_we       = 1'b1;
                            st_wd.utd   = 1'b1;
                            st_wd.dirty = 1'b0;
                            n_res = '{scd_pkg::ST_DONE, r_slot, q_tag, 1'b0, 1'b1, 1'b1};
                        end else begin
                            n_res = '{scd_pkg::ST_DONE, r_slot, 32'd0, 1'b0, 1'b0, 1'b1};
                        end
                    end

                    scd_pkg::CMD_ZERO: begin
                        n_o_valid = 1'b1;
                        if (!q_st.valid || !q_st.wr) begin
                            n_res = '{scd_pkg::ST_ERROR, r_slot, 32'd0, 1'b0, 1'b0, 1'b1};
                        end else begin
                            st_we       = 1'b1;
                            st_wd.utd   = 1'b1;
                            st_wd.dirty = 1'b1;
                            n_res = '{scd_pkg::ST_DONE, r_slot, 32'd0, 1'b0, 1'b0, 1'b1};
                        end
                    end

                    scd_pkg::CMD_DIRTY: begin
                        n_o_valid = 1'b1;
                        if (!q_st.valid || !pinned || !q_st.utd) begin
                            n_res = '{scd_pkg::ST_ERROR, r_slot, 32'd0, 1'b0, 1'b0, 1'b1};
                        end else begin
                            st_we       = 1'b1;
                            st_wd.dirty = 1'b1;
                            n_res = '{scd_pkg::ST_DONE, r_slot, 32'd0, 1'b0, 1'b0, 1'b1};
                        end
                    end

                    // flush: each write-back beat is held back until the next candidate
                    // is found so that the final one can carry last
                    scd_pkg::CMD_FLUSH: begin
                        if (cand && r_hold_v && !o_free) begin
                            n_state = scd_pkg::S_EV;
                        end else begin
                            if (cand) begin
                                st_we       = 1'b1;
                                st_wd.dirty = 1'b0;
                                if (r_hold_v) begin
                                    n_o_valid = 1'b1;
                                    n_res = '{scd_pkg::ST_DONE, 6'(r_hold_idx), r_hold_tag,
                                              1'b1, 1'b0, 1'b0};
                                end
                                n_hold_v   = 1'b1;
                                n_hold_idx = r_idx;
                                n_hold_tag = q_tag;
                                n_k        = r_k + 1'b1;
                            end
                            if ((cand && r_k == scd_pkg::KW'(scd_pkg::MAX_OUT - 1))
                                || r_idx == LAST_IDX) begin
                                n_state = scd_pkg::S_FL_END;
                            end else begin
                                n_idx   = r_idx + 1'b1;
                                n_state = scd_pkg::S_RD;
                            end
                        end
                    end

                    default: begin
                        n_state = scd_pkg::S_IDLE;
                    end
                endcase
            end

            scd_pkg::S_HAND_RD: begin
                n_state = scd_pkg::S_HAND_EV;
            end

            // clock hand walk for a victim
            scd_pkg::S_HAND_EV: begin
                n_hand = (r_hand == LAST_IDX) ? '0 : r_hand + 1'b1;
                if (!pinned) begin
                    st_we  = 1'b1;
                    st_wa  = r_hand;
                    st_wd  = '{1'b1, excl ? 8'd0 : 8'd1, excl, 1'b0, 1'b0};
                    tag_we = 1'b1;
                    tag_wa = r_hand;
                    n_o_valid = 1'b1;
                    n_res = '{scd_pkg::ST_EVICT, 6'(r_hand),
                              (q_st.utd && q_st.dirty) ? q_tag : 32'd0,
                              q_st.utd && q_st.dirty, 1'b0, 1'b1};
                    n_state = scd_pkg::S_IDLE;
                end else if (r_n == NW'(SLOTS - 1)) begin
                    n_o_valid = 1'b1;
                    n_res = '{scd_pkg::ST_FULL, 6'd0, 32'd0, 1'b0, 1'b0, 1'b1};
                    n_state = scd_pkg::S_IDLE;
                end else begin
                    n_n     = r_n + 1'b1;
                    n_state = scd_pkg::S_HAND_RD;
                end
            end

            // final flush beat
            scd_pkg::S_FL_END: begin
                if (o_free) begin
                    n_o_valid = 1'b1;
                    n_state   = scd_pkg::S_IDLE;
                    if (r_hold_v) begin
                        n_res = '{scd_pkg::ST_DONE, 6'(r_hold_idx), r_hold_tag,
                                  1'b1, 1'b0, 1'b1};
                    end else begin
                        n_res = '{scd_pkg::ST_DONE, 6'd0, 32'd0, 1'b0, 1'b0, 1'b1};
                    end
                end
            end

            default: begin
                n_state = scd_pkg::S_IDLE;
            end
        endcase
    end

    // result ports
    assign o_out_valid   = r_o_valid;
    assign o_status      = r_res.status;
    assign o_slot_out    = r_res.slot;
    assign o_disk_sector = r_res.sector;
    assign o_write_back  = r_res.wb;
    assign o_read_needed = r_res.rn;
    assign o_last        = r_res.last;

`ifndef SYNTHESIS
    // no result beat while the status memory is being cleared
    a_clear_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == scd_pkg::S_CLEAR) |-> !o_out_valid)
        else $error("result beat during clearing pass");

    // a command is only taken with an empty output register
    a_accept_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_ready |-> !r_o_valid)
        else $error("command taken while a result beat waits");

    // the hand walk never exceeds one full turn
    a_hand_turn: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == scd_pkg::S_HAND_EV) |-> (r_n < NW'(SLOTS)))
        else $error("clock hand walked past a full turn");

    // flush never holds more write-backs than allowed
    a_flush_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_k <= scd_pkg::KW'(scd_pkg::MAX_OUT)))
        else $error("flush beat count overflow");
`endif

endmodule

FILE: tb/sv/sector_cache_directory_core_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// sector_cache_directory_core_tb
// Self-checking bench for the sector cache directory. A scoreboard holds a
// copy of the directory state, works out the result beats of every accepted
// command and compares them in order with the beats the core gives. Both
// channels stall at random; the stimulus mixes lock/fill/dirty/unlock
// sequences over a small sector pool with noise and broken commands.
// ----------------------------------------------------------------------------

class scd_scoreboard;
    bit              ent_valid [64];
    bit [31:0]       ent_tag [64];
    bit [7:0]        rd_cnt [64];
    bit              wr_held [64];
    bit              utd [64];
    bit              dirty [64];
    int              hand;
    scd_pkg::t_res   pending [$];
    int              errors;

    function bit is_pinned(int i);
        return rd_cnt[i] != 0 || wr_held[i];
    endfunction

    function void push(scd_pkg::t_status st, int s, bit [31:0] sec, bit wb, bit rn,
                       bit lst);
        scd_pkg::t_res r;
        r.status = st; r.slot = s[5:0]; r.sector = sec;
        r.wb = wb; r.rn = rn; r.last = lst;
        pending.push_back(r);
    endfunction

    function void claim(int i, bit [31:0] sec, bit excl);
        ent_valid[i] = 1; ent_tag[i] = sec; utd[i] = 0; dirty[i] = 0;
        rd_cnt[i] = excl ? 8'd0 : 8'd1; wr_held[i] = excl;
    endfunction

    function void lock(bit [31:0] sec, bit excl);
        int i;
        bit wb;
        for (i = 0; i < 64; i++)
            if (ent_valid[i] && ent_tag[i] == sec) begin
                if (excl ? is_pinned(i)
                         : (wr_held[i] || rd_cnt[i] == scd_pkg::RCNT_MAX)) begin
                    push(scd_pkg::ST_BUSY, i, 0, 0, 0, 1);
                    return;
                end
                if (excl) wr_held[i] = 1;
                else rd_cnt[i]++;
                push(scd_pkg::ST_HIT, i, 0, 0, 0, 1);
                return;
            end
        for (i = 0; i < 64; i++)
            if (!ent_valid[i]) begin
                claim(i, sec, excl);
                push(scd_pkg::ST_ALLOC, i, 0, 0, 0, 1);
                return;
            end
        for (int n = 0; n < 64; n++) begin
            i = hand;
            hand = (hand + 1) % 64;
            if (!is_pinned(i)) begin
                wb = utd[i] && dirty[i];
                push(scd_pkg::ST_EVICT, i, wb ? ent_tag[i] : 32'd0, wb, 0, 1);
                claim(i, sec, excl);
                return;
            end
        end
        push(scd_pkg::ST_FULL, 0, 0, 0, 0, 1);
    endfunction

    // note an accepted command and queue its expected beats
    function void note_command(scd_pkg::t_cmd cmd, bit [31:0] sec, bit [5:0] s);
        bit ok;
        int k;
        ok = ent_valid[s];
        case (cmd)
            scd_pkg::CMD_LOCK_SH, scd_pkg::CMD_LOCK_EX: begin
                lock(sec, cmd == scd_pkg::CMD_LOCK_EX);
                return;
            end
            scd_pkg::CMD_UNLOCK: if (ok && is_pinned(s)) begin
                if (rd_cnt[s] != 0) rd_cnt[s]--;
                else wr_held[s] = 0;
                push(scd_pkg::ST_DONE, s, 0, 0, 0, 1);
                return;
            end
            scd_pkg::CMD_FILL: if (ok && is_pinned(s)) begin
                if (!utd[s]) begin
                    utd[s] = 1; dirty[s] = 0;
                    push(scd_pkg::ST_DONE, s, ent_tag[s], 0, 1, 1);
                end else push(scd_pkg::ST_DONE, s, 0, 0, 0, 1);
                return;
            end
            scd_pkg::CMD_ZERO: if (ok && wr_held[s]) begin
                utd[s] = 1; dirty[s] = 1;
                push(scd_pkg::ST_DONE, s, 0, 0, 0, 1);
                return;
            end
            scd_pkg::CMD_DIRTY: if (ok && is_pinned(s) && utd[s]) begin
                dirty[s] = 1;
                push(scd_pkg::ST_DONE, s, 0, 0, 0, 1);
                return;
            end
            scd_pkg::CMD_FREE: begin
                for (int i = 0; i < 64; i++)
                    if (ent_valid[i] && ent_tag[i] == sec) begin
                        if (!is_pinned(i)) ent_valid[i] = 0;
                        break;
                    end
                push(scd_pkg::ST_DONE, 0, 0, 0, 0, 1);
                return;
            end
            default: begin
                k = 0;
                for (int i = 0; i < 64; i++)
                    if (ent_valid[i] && utd[i] && dirty[i] && !wr_held[i]) begin
                        dirty[i] = 0;
                        push(scd_pkg::ST_DONE, i, ent_tag[i], 1, 0, 0);
                        k++;
                    end
                if (k == 0) push(scd_pkg::ST_DONE, 0, 0, 0, 0, 1);
                else pending[$].last = 1;
                return;
            end
        endcase
        push(scd_pkg::ST_ERROR, s, 0, 0, 0, 1);
    endfunction

    // compare one result beat with the oldest expectation
    function void check_beat(scd_pkg::t_res got);
        scd_pkg::t_res exp;
        if (pending.size() == 0) begin
            $error("unexpected result beat, status %0d", got.status);
            errors++;
            return;
        end
        exp = pending.pop_front();
        if (got.status !== exp.status) begin
            $error("status: expected %0d, got %0d", exp.status, got.status); errors++;
        end
        if (got.slot !== exp.slot) begin
            $error("slot_out: expected %0d, got %0d", exp.slot, got.slot); errors++;
        end
        if (got.sector !== exp.sector) begin
            $error("disk_sector: expected %h, got %h", exp.sector, got.sector); errors++;
        end
        if (got.wb !== exp.wb) begin
            $error("write_back: expected %b, got %b", exp.wb, got.wb); errors++;
        end
        if (got.rn !== exp.rn) begin
            $error("read_needed: expected %b, got %b", exp.rn, got.rn); errors++;
        end
        if (got.last !== exp.last) begin
            $error("last: expected %b, got %b", exp.last, got.last); errors++;
        end
    endfunction
endclass

module sector_cache_directory_core_tb;

    logic        i_clk = 0;
    logic        i_rst_n = 0;
    logic        i_in_valid = 0;
    logic [2:0]  i_cmd = '0;
    logic [31:0] i_sector = '0;
    logic [5:0]  i_slot = '0;
    logic        i_out_ready = 0;
    logic        o_in_ready, o_out_valid, o_write_back, o_read_needed, o_last;
    logic [2:0]  o_status;
    logic [5:0]  o_slot_out;
    logic [31:0] o_disk_sector;

    scd_scoreboard dir_model = new();
    bit            calm = 0;
    bit [31:0]     sector_pool [8];

    sector_cache_directory_core DUT (.*);

    always #5 i_clk = ~i_clk;

    // send one command beat, with random idle cycles ahead of it
    task automatic send_cmd(scd_pkg::t_cmd cmd, bit [31:0] sec, bit [5:0] s);
        if (!calm && $urandom_range(99) < 24) begin
            i_in_valid <= 0;
            do @(posedge i_clk); while (!calm && $urandom_range(99) < 24);
        end
        i_in_valid <= 1; i_cmd <= cmd; i_sector <= sec; i_slot <= s;
        do @(posedge i_clk); while (!o_in_ready);
        dir_model.note_command(cmd, sec, s);
    endtask

    // result side: random stalls, check on each accepted beat
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready)
            dir_model.check_beat({scd_pkg::t_status'(o_status), o_slot_out, o_disk_sector,
                                  o_write_back, o_read_needed, o_last});
        i_out_ready <= calm || ($urandom_range(99) >= 24);
    end

    function automatic bit [5:0] any_slot();
        return $urandom_range(3) == 0 ? 6'($urandom) : 6'($urandom_range(7));
    endfunction

    initial begin
        scd_pkg::t_cmd cmd;
        bit [31:0]     sec;
        bit [5:0]      s;
        int            pick;
        foreach (sector_pool[j]) sector_pool[j] = $urandom;
        sector_pool[0] = 32'hFFFF_FFFF;
        sector_pool[1] = 32'h0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1;

        // directed: extremes and each special case
        send_cmd(scd_pkg::CMD_UNLOCK, 0, 6'd63);
        send_cmd(scd_pkg::CMD_FILL, 0, 6'd0);
        send_cmd(scd_pkg::CMD_FLUSH, 0, 0);
        send_cmd(scd_pkg::CMD_LOCK_EX, 32'hFFFF_FFFF, 0);
        send_cmd(scd_pkg::CMD_LOCK_SH, 32'hFFFF_FFFF, 0);
        send_cmd(scd_pkg::CMD_ZERO, 0, 6'd0);
        send_cmd(scd_pkg::CMD_DIRTY, 0, 6'd0);
        send_cmd(scd_pkg::CMD_FLUSH, 0, 0);
        send_cmd(scd_pkg::CMD_UNLOCK, 0, 6'd0);
        send_cmd(scd_pkg::CMD_FLUSH, 0, 0);
        send_cmd(scd_pkg::CMD_LOCK_SH, 32'h0, 0);
        send_cmd(scd_pkg::CMD_FILL, 0, 6'd1);
        send_cmd(scd_pkg::CMD_FILL, 0, 6'd1);
        send_cmd(scd_pkg::CMD_DIRTY, 0, 6'd1);
        send_cmd(scd_pkg::CMD_LOCK_EX, 32'h0, 0);
        send_cmd(scd_pkg::CMD_UNLOCK, 0, 6'd1);
        send_cmd(scd_pkg::CMD_FREE, 32'hFFFF_FFFF, 0);
        send_cmd(scd_pkg::CMD_FREE, 32'h1234_5678, 0);
        send_cmd(scd_pkg::CMD_ZERO, 0, 6'd1);
        send_cmd(scd_pkg::CMD_UNLOCK, 0, 6'd1);
        // fill the whole directory with pinned slots, then overflow
        for (int j = 0; j < 65; j++) send_cmd(scd_pkg::CMD_LOCK_SH, 32'h100 + j, 0);
        // release and dirty some, then force an eviction and a flush
        for (int j = 0; j < 4; j++) begin
            send_cmd(scd_pkg::CMD_FILL, 0, j[5:0]);
            send_cmd(scd_pkg::CMD_DIRTY, 0, j[5:0]);
            send_cmd(scd_pkg::CMD_UNLOCK, 0, j[5:0]);
        end
        send_cmd(scd_pkg::CMD_LOCK_EX, 32'h5000, 0);
        send_cmd(scd_pkg::CMD_FLUSH, 0, 0);
        // saturate one reader count; no idling on either side here
        calm = 1;
        for (int j = 0; j < 256; j++) send_cmd(scd_pkg::CMD_LOCK_SH, 32'h7777, 0);
        calm = 0;

        // random part
        for (int n = 0; n < 20; n++) begin
            pick = $urandom_range(99);
            sec = $urandom_range(9) == 0 ? 32'($urandom) : sector_pool[$urandom_range(7)];
            s = any_slot();
            if (pick < 30) cmd = $urandom_range(1) ? scd_pkg::CMD_LOCK_SH
                                                   : scd_pkg::CMD_LOCK_EX;
            else if (pick < 45) cmd = scd_pkg::CMD_FILL;
            else if (pick < 55) cmd = scd_pkg::CMD_ZERO;
            else if (pick < 65) cmd = scd_pkg::CMD_DIRTY;
            else if (pick < 85) cmd = scd_pkg::CMD_UNLOCK;
            else if (pick < 93) cmd = scd_pkg::CMD_FREE;
            else cmd = scd_pkg::CMD_FLUSH;
            send_cmd(cmd, sec, s);
        end
        i_in_valid <= 0;

        while (dir_model.pending.size() != 0) @(posedge i_clk);
        repeat (300) @(posedge i_clk);
        if (dir_model.errors == 0 && dir_model.pending.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    initial begin
        #20ms;
        $display("simulation failed");
        $finish;
    end

endmodule
